>>> design/wmm_pkg.sv
// ----------------------------------------------------------------------------
// wmm_pkg
// Shared types and constants for the window median and mean block.
// ----------------------------------------------------------------------------
package wmm_pkg;

  localparam int POSITIONS  = 65536;
  localparam int MAX_WINDOW = 1024;
  localparam int DEPTH_BITS = 16;

  localparam int POS_W   = $clog2(POSITIONS);
  localparam int CNT_W   = $clog2(MAX_WINDOW) + 1;
  localparam int SUM_W   = 26;
  localparam int MEAN_W  = 24;
  localparam int DIVD_W  = SUM_W + 8;
  localparam int MED_W   = 16;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_STORE = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  ins_valid;
    logic [DEPTH_BITS-1:0] ins_value;
  } sort_ctrl_t;

endpackage

>>> design/wmm_sort_cell.sv
// ----------------------------------------------------------------------------
// wmm_sort_cell
// One cell of the insertion sort chain: keeps the chain ascending.
// ----------------------------------------------------------------------------
module wmm_sort_cell
  import wmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  logic                  ins_valid,
  input  logic [DEPTH_BITS-1:0] ins_value,
  input  logic                  prev_valid,
  input  logic                  prev_gt,
  input  logic [DEPTH_BITS-1:0] prev_value,
  output logic                  cell_valid,
  output logic                  cell_gt,
  output logic [DEPTH_BITS-1:0] cell_value
);

  logic                  valid_r;
  logic [DEPTH_BITS-1:0] value_r;

  assign cell_valid = valid_r;
  assign cell_value = value_r;
  assign cell_gt    = valid_r && (value_r > ins_value);

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= 1'b0;
    end else if (ins_valid) begin
      if (cell_gt) begin
        valid_r <= 1'b1;
        value_r <= (prev_gt && prev_valid) ? prev_value : ins_value;
      end else if (!valid_r && !(prev_valid && prev_gt) && prev_valid) begin
        valid_r <= 1'b1;
        value_r <= ins_value;
      end else if (!valid_r && prev_valid && prev_gt) begin
        valid_r <= 1'b1;
        value_r <= prev_value;
      end
    end
  end

endmodule

>>> design/wmm_sort_chain.sv
// ----------------------------------------------------------------------------
// wmm_sort_chain
// Row of sort cells; the median is picked through a registered read.
// ----------------------------------------------------------------------------
module wmm_sort_chain
  import wmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  sort_ctrl_t            ctrl,
  input  logic [CNT_W-2:0]      pick_idx,
  output logic [DEPTH_BITS-1:0] pick_value
);

  logic [MAX_WINDOW-1:0]  vld;
  logic [MAX_WINDOW-1:0]  gt;
  logic [DEPTH_BITS-1:0]  val [MAX_WINDOW];
  logic [DEPTH_BITS-1:0]  pick_r;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_first
      wmm_sort_cell u_cell (
        .clk, .rst_n, .clear,
        .ins_valid (ctrl.ins_valid),
        .ins_value (ctrl.ins_value),
        .prev_valid(1'b1),
        .prev_gt   (1'b0),
        .prev_value(ctrl.ins_value),
        .cell_valid(vld[i]),
        .cell_gt   (gt[i]),
        .cell_value(val[i])
      );
    end else begin : g_rest
      wmm_sort_cell u_cell (
        .clk, .rst_n, .clear,
        .ins_valid (ctrl.ins_valid),
        .ins_value (ctrl.ins_value),
        .prev_valid(vld[i-1]),
        .prev_gt   (gt[i-1]),
        .prev_value(val[i-1]),
        .cell_valid(vld[i]),
        .cell_gt   (gt[i]),
        .cell_value(val[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    pick_r <= val[pick_idx];
  end

  assign pick_value = pick_r;

endmodule

>>> design/wmm_divider.sv
// ----------------------------------------------------------------------------
// wmm_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wmm_divider
  import wmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quo_r;
  logic [CNT_W:0]    rem_r;
  logic [CNT_W-1:0]  dsr_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    trial;

  assign trial    = {rem_r[CNT_W-1:0], quo_r[DIVD_W-1]};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
        step_r <= STEP_W'(DIVD_W);
      end else if (busy_r) begin
        if (trial >= {1'b0, dsr_r}) begin
          rem_r <= trial - {1'b0, dsr_r};
          quo_r <= {quo_r[DIVD_W-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[DIVD_W-2:0], 1'b0};
        end
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/window_median_mean_top.sv
// ----------------------------------------------------------------------------
// window_median_mean_top
// Range median and mean query over a sparse per-position depth store.
// ----------------------------------------------------------------------------
// Usage: drive in_* and pulse start while busy is low; the request is taken
// at that edge. A clear request sweeps the present marks, one per cycle. A
// store request writes the depth and sets the present mark at that edge. A
// query request reads one position per cycle from the store, inserting each
// present depth into an insertion sort chain of 1024 cells, then picks the
// median and runs the divider for the mean. An empty or too-long window
// skips the scan and the divider. The result shows on out_* for one cycle
// with out_valid; the receiver cannot stall and must take it.
// After reset the present marks are swept clear, during which busy stays
// high. Code 3 is dropped with no result.
// ----------------------------------------------------------------------------
module window_median_mean_top
  import wmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_operation,
  input  logic [15:0]           in_position,
  input  logic [15:0]           in_window_end,
  input  logic [15:0]           in_depth_value,
  output logic                  out_valid,
  output logic [MED_W-1:0]      out_median_depth,
  output logic [SUM_W-1:0]      out_depth_sum,
  output logic [CNT_W-1:0]      out_sample_count,
  output logic [MEAN_W-1:0]     out_mean_fixed,
  output logic                  out_window_too_long
);

  logic [DEPTH_BITS-1:0] store_mem [POSITIONS];
  logic                  mark_mem  [POSITIONS];

  state_t state_r, state_nxt;
  logic [POS_W:0]        ptr_r, ptr_nxt;
  logic [POS_W:0]        stop_r, stop_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [DEPTH_BITS-1:0] rd_depth_r;
  logic                  rd_mark_r;
  logic                  pick_wait_r, pick_wait_nxt;
  logic [MED_W-1:0]      med_r, med_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  flag_r, flag_nxt;
  logic                  chain_clear;
  logic                  div_go, div_done;
  logic [DIVD_W-1:0]     div_q;
  logic [DEPTH_BITS-1:0] pick_value;
  logic                  mark_we, mark_wd, store_we;
  logic [POS_W-1:0]      mark_addr;
  sort_ctrl_t            sctrl;
  logic [16:0]           span;
  logic                  take;

  assign take = rd_pend_r && rd_mark_r && (cnt_r < CNT_W'(MAX_WINDOW));
  assign sctrl.ins_valid = take;
  assign sctrl.ins_value = rd_depth_r;

  wmm_sort_chain u_chain (
    .clk, .rst_n,
    .clear     (chain_clear),
    .ctrl      (sctrl),
    .pick_idx  (cnt_r[CNT_W-1:1]),
    .pick_value(pick_value)
  );

  wmm_divider u_div (
    .clk, .rst_n,
    .go      (div_go),
    .dividend({sum_r, 8'd0}),
    .divisor (cnt_r),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[in_position[POS_W-1:0]] <= in_depth_value[DEPTH_BITS-1:0];
    end
    if (mark_we) begin
      mark_mem[mark_addr] <= mark_wd;
    end
    rd_depth_r <= store_mem[ptr_r[POS_W-1:0]];
    rd_mark_r  <= mark_mem[ptr_r[POS_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      rd_pend_r   <= 1'b0;
      pick_wait_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      pick_wait_r <= pick_wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
    stop_r <= stop_nxt;
    cnt_r  <= cnt_nxt;
    sum_r  <= sum_nxt;
    med_r  <= med_nxt;
    flag_r <= flag_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    stop_nxt      = stop_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    rd_pend_nxt   = 1'b0;
    pick_wait_nxt = 1'b0;
    med_nxt       = med_r;
    out_valid_nxt = 1'b0;
    flag_nxt      = flag_r;
    chain_clear   = 1'b0;
    div_go        = 1'b0;
    mark_we       = 1'b0;
    mark_wd       = 1'b0;
    mark_addr     = ptr_r[POS_W-1:0];
    store_we      = 1'b0;
    busy          = 1'b1;
    span          = {1'b0, in_window_end} - {1'b0, in_position};
    if (take) begin
      cnt_nxt = cnt_r + 1'b1;
      sum_nxt = sum_r + SUM_W'(rd_depth_r);
    end
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (op_t'(in_operation))
            OP_CLEAR: begin
              ptr_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            OP_STORE: begin
              store_we  = 1'b1;
              mark_we   = 1'b1;
              mark_wd   = 1'b1;
              mark_addr = in_position[POS_W-1:0];
            end
            OP_QUERY: begin
              cnt_nxt     = '0;
              sum_nxt     = '0;
              med_nxt     = '0;
              flag_nxt    = 1'b0;
              chain_clear = 1'b1;
              if (in_window_end < in_position) begin
                state_nxt = ST_DONE;
              end else if (span >= 17'(MAX_WINDOW)) begin
                flag_nxt  = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                ptr_nxt   = {1'b0, in_position};
                stop_nxt  = {1'b0, in_window_end};
                state_nxt = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        mark_we = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r[POS_W-1:0] == POS_W'(POSITIONS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        rd_pend_nxt = 1'b1;
        ptr_nxt     = ptr_r + 1'b1;
        if (ptr_r == stop_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        pick_wait_nxt = 1'b1;
        if (pick_wait_r) begin
          if (cnt_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            med_nxt   = pick_value;
            div_go    = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [MEAN_W-1:0] mean_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      mean_r <= '0;
    end else if (div_done) begin
      mean_r <= div_q[MEAN_W-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_median_depth    = med_r;
  assign out_depth_sum       = sum_r;
  assign out_sample_count    = cnt_r;
  assign out_mean_fixed      = mean_r;
  assign out_window_too_long = flag_r;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks window_median_mean_top: clear, store and query requests are sent as
// a directed table and then as clustered random traffic. A local depth and
// present-mark store predicts median, sum, count, mean and too-long flag
// unless a row fixes them; results are matched in order to expected answers.
// ----------------------------------------------------------------------------
module tb_top;
  import wmm_pkg::*;

  typedef struct {
    logic [MED_W-1:0]  median;
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  count;
    logic [MEAN_W-1:0] mean;
    logic              too_long;
  } answer_t;

  typedef struct {
    op_t         op;
    logic [15:0] pos;
    logic [15:0] stop;
    logic [15:0] depth;
    bit          typed;
    answer_t     ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [15:0] in_position = '0;
  logic [15:0] in_window_end = '0;
  logic [15:0] in_depth_value = '0;
  logic        out_valid;
  logic [MED_W-1:0]  out_median_depth;
  logic [SUM_W-1:0]  out_depth_sum;
  logic [CNT_W-1:0]  out_sample_count;
  logic [MEAN_W-1:0] out_mean_fixed;
  logic              out_window_too_long;

  logic [DEPTH_BITS-1:0] depth_mem [POSITIONS];
  bit                    present [POSITIONS];
  answer_t               pending_answers [$];
  int                    errors = 0;
  int                    clears_left = 2;

  window_median_mean_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic answer_t window_stats(logic [15:0] first, logic [15:0] last);
    answer_t           a;
    logic [DEPTH_BITS-1:0] vals [$];
    longint unsigned   total;
    int                n;
    a = '{default: '0};
    total = 0;
    if (last >= first && int'(last) - int'(first) + 1 > MAX_WINDOW) begin
      a.too_long = 1'b1;
      return a;
    end
    if (last < first) return a;
    for (int p = first; p <= last; p++) begin
      if (present[p] && vals.size() < MAX_WINDOW) begin
        vals.push_back(depth_mem[p]);
        total += depth_mem[p];
      end
    end
    n = vals.size();
    if (n != 0) begin
      vals.sort();
      a.median = vals[n / 2];
      a.sum = SUM_W'(total);
      a.count = CNT_W'(n);
      a.mean = MEAN_W'((total << 8) / longint'(n));
    end
    return a;
  endfunction

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send(row_t r);
    idle_gap();
    start = 1'b1;
    in_operation = r.op;
    in_position = r.pos;
    in_window_end = r.stop;
    in_depth_value = r.depth;
    do @(posedge clk); while (busy);
    case (r.op)
      OP_CLEAR: present = '{default: 1'b0};
      OP_STORE: begin
        depth_mem[r.pos] = r.depth;
        present[r.pos] = 1'b1;
      end
      OP_QUERY: pending_answers.push_back(r.typed ? r.ans : window_stats(r.pos, r.stop));
      default: ;
    endcase
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic row_t mk(op_t op, int pos, int stop, int depth);
    row_t r;
    r.op = op;
    r.pos = 16'(pos);
    r.stop = 16'(stop);
    r.depth = 16'(depth);
    r.typed = 1'b0;
    r.ans = '{default: '0};
    return r;
  endfunction

  function automatic row_t mk_typed(int pos, int stop, bit flag);
    row_t r;
    r = mk(OP_QUERY, pos, stop, 0);
    r.typed = 1'b1;
    r.ans.too_long = flag;
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result median=%0d sum=%0d count=%0d", $time,
                 out_median_depth, out_depth_sum, out_sample_count);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (out_median_depth !== e.median) begin
          $display("%0t: median exp %0d got %0d", $time, e.median, out_median_depth);
          errors++;
        end
        if (out_depth_sum !== e.sum) begin
          $display("%0t: sum exp %0d got %0d", $time, e.sum, out_depth_sum);
          errors++;
        end
        if (out_sample_count !== e.count) begin
          $display("%0t: count exp %0d got %0d", $time, e.count, out_sample_count);
          errors++;
        end
        if (out_mean_fixed !== e.mean) begin
          $display("%0t: mean exp %0d got %0d", $time, e.mean, out_mean_fixed);
          errors++;
        end
        if (out_window_too_long !== e.too_long) begin
          $display("%0t: too_long exp %0d got %0d", $time, e.too_long,
                   out_window_too_long);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t directed [$];
    row_t r;
    int   items;
    int   base;
    int   pick;
    int   len;
    int   first;

    present = '{default: 1'b0};
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    directed = '{
      mk_typed(0, 1023, 1'b0),
      mk_typed(0, 1024, 1'b1),
      mk_typed(0, 65535, 1'b1),
      mk_typed(500, 499, 1'b0),
      mk_typed(65535, 0, 1'b0),
      mk(OP_STORE, 0, 0, 0),
      mk(OP_STORE, 65535, 0, 65535),
      mk(OP_STORE, 1, 0, 16'hffff),
      mk(OP_STORE, 2, 0, 16'h5555),
      mk(OP_STORE, 3, 0, 16'haaaa),
      mk(OP_NONE, 2, 3, 7),
      mk(OP_QUERY, 0, 3, 0),
      mk(OP_QUERY, 1, 2, 0),
      mk(OP_QUERY, 65535, 65535, 0),
      mk(OP_QUERY, 64512, 65535, 0),
      mk(OP_STORE, 2, 0, 9),
      mk(OP_QUERY, 0, 1023, 0),
      mk(OP_CLEAR, 0, 0, 0),
      mk_typed(0, 3, 1'b0),
      mk(OP_STORE, 40000, 0, 123),
      mk(OP_QUERY, 39999, 40001, 0)
    };
    foreach (directed[i]) send(directed[i]);

    for (int p = 0; p < 200; p++) send(mk(OP_STORE, p, 0, $urandom_range(0, 65535)));
    send(mk(OP_QUERY, 0, 1023, 0));
    send(mk(OP_QUERY, 0, 1500, 0));
    send(mk(OP_QUERY, 100, 1122, 0));

    items = 0;
    base = $urandom_range(0, 65535);
    while (items < 316) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) base = $urandom_range(0, 65535);
      if (pick < 58) begin
        r = mk(OP_STORE, (base + $urandom_range(0, 60)) % POSITIONS, $urandom(),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 65535));
      end else if (pick < 96) begin
        first = (base + $urandom_range(0, 50)) % POSITIONS;
        case ($urandom_range(0, 24))
          0, 1:    len = $urandom_range(1025, 70000);
          2:       len = -$urandom_range(1, 65535);
          3, 4, 5: len = $urandom_range(41, 1024);
          default: len = $urandom_range(1, 40);
        endcase
        first = (len < 0) ? first : first;
        r = mk(OP_QUERY, first, (first + len - 1) & 16'hffff, $urandom());
        if (len > 0 && first + len - 1 > 65535)
          r.stop = 16'hffff;
      end else if (pick < 98 || clears_left == 0) begin
        r = mk(OP_NONE, $urandom(), $urandom(), $urandom());
      end else begin
        clears_left--;
        r = mk(OP_CLEAR, $urandom(), $urandom(), $urandom());
      end
      send(r);
      items++;
    end

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
